// ===== design/sat_pkg.sv =====
package sat_pkg;

  // table geometry
  localparam int unsigned MaxSegments = 16;
  localparam int unsigned IdxW   = (MaxSegments > 1) ? $clog2(MaxSegments) : 1;
  localparam int unsigned CountW = $clog2(MaxSegments + 1);

  // field widths
  localparam int unsigned IdW    = 16;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned EndW   = AddrW + 1;
  localparam int unsigned StatW  = 3;
  localparam int unsigned EntW   = 5;

  // command codes
  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdClear = 1'b1;

  // result status codes
  typedef enum logic [StatW-1:0] {
    StatOk      = 3'd0,
    StatRange   = 3'd1,
    StatDupId   = 3'd2,
    StatOverlap = 3'd3,
    StatFull    = 3'd4
  } sat_status_e;

endpackage

// ===== design/segment_allocation_table.sv =====
// sequence: a clear or an out-of-range request has its result registered from the
// range state; an allocate goes from the range state through a scan of the stored
// entries, if any, to the append state, or ends the scan with a reject on a hit
// throughput: one item at a time, the input stalls until the result is registered,
// and a result-side stall holds the sequencer in the state whose result is ready;
// the scan is done by the single compare unit that walks the table one entry per
// cycle through the registered read port
// reset: the entry count, total memory and all control clear; table contents
// stay undefined and are only compared below the entry count
module segment_allocation_table import sat_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             cfg_we_i,
  input  logic [AddrW-1:0] cfg_wdata_i,
  // request channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             cmd_i,
  input  logic [IdW-1:0]   owner_id_i,
  input  logic [IdW-1:0]   segment_id_i,
  input  logic [AddrW-1:0] segment_base_i,
  input  logic [AddrW-1:0] segment_length_i,
  // result channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [StatW-1:0] status_o,
  output logic [EntW-1:0]  entries_used_o
);

  typedef enum logic [1:0] {
    SIdle,
    SRange,
    SScan,
    SAppend
  } state_e;

  // stored entry: the end is kept at 33 bits so the scan needs no adder
  typedef struct packed {
    logic [IdW-1:0]   ident;
    logic [AddrW-1:0] start;
    logic [EndW-1:0]  stop;
  } seg_entry_t;

  state_e                state_q, state_d;
  logic [CountW-1:0]     count_q, count_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [AddrW-1:0]      total_q, total_d;
  logic                  out_valid_q, out_valid_d;
  sat_status_e           status_q, status_d;

  logic                  req_clr_q, req_clr_d;
  logic [IdW-1:0]        req_owner_q, req_owner_d;
  logic [IdW-1:0]        req_id_q, req_id_d;
  logic [AddrW-1:0]      req_base_q, req_base_d;
  logic [EndW-1:0]       req_end_q, req_end_d;

  seg_entry_t            seg_mem_q [MaxSegments];
  logic [IdW-1:0]        seg_owner_q [MaxSegments];
  seg_entry_t            rd_q;
  logic [IdxW-1:0]       rd_addr;
  logic                  wr_en;
  logic [IdxW-1:0]       wr_addr;

  logic                  in_xfer;
  logic                  out_free;
  logic                  id_hit;
  logic                  ovl_hit;
  logic                  scan_last;
  logic [EndW-1:0]       a_ext;
  logic [EndW-1:0]       b_ext;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // compare unit: current request against the entry read last cycle
  assign a_ext   = {1'b0, req_base_q};
  assign b_ext   = {1'b0, rd_q.start};
  assign id_hit  = (rd_q.ident == req_id_q);
  assign ovl_hit = ((a_ext >= b_ext) && (a_ext < rd_q.stop)) ||
                   ((req_end_q > b_ext) && (req_end_q <= rd_q.stop)) ||
                   ((b_ext >= a_ext) && (b_ext < req_end_q)) ||
                   ((rd_q.stop > a_ext) && (rd_q.stop <= req_end_q));
  assign scan_last = ((CountW+1)'(idx_q) + (CountW+1)'(1)) >= (CountW+1)'(count_q);

  // read address follows the next scan index, so a held compare keeps its entry
  assign rd_addr = idx_d;
  assign wr_addr = count_q[IdxW-1:0];

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    total_d     = total_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    req_clr_d   = req_clr_q;
    req_owner_d = req_owner_q;
    req_id_d    = req_id_q;
    req_base_d  = req_base_q;
    req_end_d   = req_end_q;
    wr_en       = 1'b0;

    if (cfg_we_i) begin
      total_d = cfg_wdata_i;
    end
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      SIdle: begin
        if (in_xfer) begin
          req_clr_d   = (cmd_i == CmdClear);
          req_owner_d = owner_id_i;
          req_id_d    = segment_id_i;
          req_base_d  = segment_base_i;
          req_end_d   = {1'b0, segment_base_i} + {1'b0, segment_length_i};
          state_d     = SRange;
        end
      end
      SRange: begin
        if (req_clr_q) begin
          if (out_free) begin
            count_d     = '0;
            status_d    = StatOk;
            out_valid_d = 1'b1;
            state_d     = SIdle;
          end
        end else if (req_end_q > {1'b0, total_q}) begin
          if (out_free) begin
            status_d    = StatRange;
            out_valid_d = 1'b1;
            state_d     = SIdle;
          end
        end else if (count_q == '0) begin
          state_d = SAppend;
        end else begin
          idx_d   = '0;
          state_d = SScan;
        end
      end
      SScan: begin
        if (id_hit || ovl_hit) begin
          if (out_free) begin
            status_d    = id_hit ? StatDupId : StatOverlap;
            out_valid_d = 1'b1;
            state_d     = SIdle;
          end
        end else if (scan_last) begin
          state_d = SAppend;
        end else begin
          idx_d = IdxW'(idx_q + IdxW'(1));
        end
      end
      SAppend: begin
        if (out_free) begin
          if (count_q >= CountW'(MaxSegments)) begin
            status_d = StatFull;
          end else begin
            wr_en    = 1'b1;
            count_d  = CountW'(count_q + CountW'(1));
            status_d = StatOk;
          end
          out_valid_d = 1'b1;
          state_d     = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      idx_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= StatOk;
      req_clr_q   <= 1'b0;
      req_owner_q <= '0;
      req_id_q    <= '0;
      req_base_q  <= '0;
      req_end_q   <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      req_clr_q   <= req_clr_d;
      req_owner_q <= req_owner_d;
      req_id_q    <= req_id_d;
      req_base_q  <= req_base_d;
      req_end_q   <= req_end_d;
    end
  end

  // segment table with one write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      seg_mem_q[wr_addr]   <= '{ident: req_id_q, start: req_base_q, stop: req_end_q};
      seg_owner_q[wr_addr] <= req_owner_q;
    end
    rd_q <= seg_mem_q[rd_addr];
  end

  // ports
  assign in_stall_o     = (state_q != SIdle);
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign entries_used_o = EntW'(count_q);

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxSegments))
    else $error("entry count above table size");

  a_scan_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SScan) |-> ((CountW+1)'(idx_q) < (CountW+1)'(count_q)))
    else $error("scan reached an unwritten entry");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == StatFull)) |-> (count_q == CountW'(MaxSegments)))
    else $error("full status with room left");

  a_reject_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SScan && (id_hit || ovl_hit) && out_free) |=>
      (count_q == $past(count_q)))
    else $error("rejected request changed the table");

endmodule
